// ===== sv/ssr_pkg.sv =====
package ssr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_of_text;
    logic       failed;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic release_oldest;
    logic clear_window;
    logic rep_start;
    logic rep_emit;
    logic fail;
    logic finish;
  } ssr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic plen_zero;
    logic rlen_zero;
    logic prefix_ok;
    logic full_match;
    logic fill_zero;
    logic fill_one;
    logic rep_last;
    logic slot_free;
    logic fin;
  } ssr_sts_t;

endpackage

// ===== sv/ssr_dp.sv =====
module ssr_dp
  import ssr_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  ssr_cmd_t              cmd,
  output ssr_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  localparam int FW = $clog2(PATTERN_MAX + 1);
  localparam int RW = $clog2(REPLACE_MAX + 1);

  logic [CFG_DATA_W-1:0] pat_bytes_r, rep_bytes_r;
  logic [LEN_W-1:0]      pat_len_r, rep_len_r;

  logic [7:0]            win_r   [PATTERN_MAX];
  logic [7:0]            win_nxt [PATTERN_MAX];
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [7:0]            hold_r, hold_nxt;
  logic                  hold_vld_r, hold_vld_nxt;
  logic                  fin_r, fin_nxt;
  logic [CFG_DATA_W-1:0] rep_sh_r, rep_sh_nxt;
  logic [RW-1:0]         rep_rem_r, rep_rem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [FW-1:0]         plen_eff;
  logic [RW-1:0]         rlen_eff;
  logic                  mism;
  logic                  gen_en;
  logic [7:0]            gen_byte;

  assign plen_eff = (pat_len_r > LEN_W'(PATTERN_MAX)) ? FW'(PATTERN_MAX) : pat_len_r[FW-1:0];
  assign rlen_eff = (rep_len_r > LEN_W'(REPLACE_MAX)) ? RW'(REPLACE_MAX) : rep_len_r[RW-1:0];

  // Every held byte is compared with its pattern lane at once.
  always_comb begin
    mism = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((FW'(i) < fill_r) && (win_r[i] != pat_bytes_r[8*i +: 8])) begin
        mism = 1'b1;
      end
    end
  end

  always_comb begin
    sts.plen_zero  = (pat_len_r == '0);
    sts.rlen_zero  = (rlen_eff == '0);
    sts.prefix_ok  = !mism && (fill_r <= plen_eff);
    sts.full_match = (fill_r == plen_eff);
    sts.fill_zero  = (fill_r == '0);
    sts.fill_one   = (fill_r == FW'(1));
    sts.rep_last   = (rep_rem_r == RW'(1));
    sts.slot_free  = !out_valid_r || !out_stall;
    sts.fin        = fin_r;
  end

  // Each new result goes into a one-entry hold register, and the one it
  // displaces moves to the output. The last result of an item can then
  // still be marked as the end of the text once the item is done.
  always_comb begin
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    hold_nxt      = hold_r;
    hold_vld_nxt  = hold_vld_r;
    fin_nxt       = fin_r;
    rep_sh_nxt    = rep_sh_r;
    rep_rem_nxt   = rep_rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    gen_en        = 1'b0;
    gen_byte      = '0;

    if (cmd.accept) begin
      fin_nxt = in_data.final_byte;
      if (sts.plen_zero) begin
        fill_nxt = '0;
      end else begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
          if (fill_r == FW'(i)) begin
            win_nxt[i] = in_data.text_byte;
          end
        end
        fill_nxt = fill_r + 1'b1;
      end
    end

    if (cmd.release_oldest) begin
      gen_en   = 1'b1;
      gen_byte = win_r[0];
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      fill_nxt = fill_r - 1'b1;
    end

    if (cmd.clear_window) begin
      fill_nxt = '0;
    end

    if (cmd.rep_start) begin
      fill_nxt    = '0;
      rep_sh_nxt  = rep_bytes_r;
      rep_rem_nxt = rlen_eff;
    end

    if (cmd.rep_emit) begin
      gen_en      = 1'b1;
      gen_byte    = rep_sh_r[7:0];
      rep_sh_nxt  = rep_sh_r >> 8;
      rep_rem_nxt = rep_rem_r - 1'b1;
    end

    if (gen_en) begin
      if (hold_vld_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: hold_r, byte_present: 1'b1,
                          end_of_text: 1'b0, failed: 1'b0};
      end
      hold_nxt     = gen_byte;
      hold_vld_nxt = 1'b1;
    end

    if (cmd.fail) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{out_byte: 8'd0, byte_present: 1'b0,
                        end_of_text: 1'b0, failed: 1'b1};
    end

    if (cmd.finish) begin
      if (hold_vld_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: hold_r, byte_present: 1'b1,
                          end_of_text: fin_r, failed: 1'b0};
        hold_vld_nxt  = 1'b0;
      end else if (fin_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: 8'd0, byte_present: 1'b0,
                          end_of_text: 1'b1, failed: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= '0;
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:      pat_bytes_r <= cfg_data;
        CFG_PATTERN_LENGTH:     pat_len_r   <= cfg_data[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  rep_bytes_r <= cfg_data;
        CFG_REPLACEMENT_LENGTH: rep_len_r   <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    hold_r     <= hold_nxt;
    fin_r      <= fin_nxt;
    rep_sh_r   <= rep_sh_nxt;
    rep_rem_r  <= rep_rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/ssr_ctrl.sv =====
module ssr_ctrl
  import ssr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ssr_sts_t sts,
  output ssr_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAIL,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.plen_zero ? ST_FAIL : ST_SCAN;
        end
      end
      ST_FAIL: begin
        if (sts.slot_free) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.slot_free) begin
          priority if (!sts.prefix_ok) begin
            cmd.release_oldest = 1'b1;
            if (sts.fill_one) begin
              state_nxt = ST_FINISH;
            end
          end else if (sts.full_match) begin
            if (sts.rlen_zero) begin
              cmd.clear_window = 1'b1;
              state_nxt        = ST_FINISH;
            end else begin
              cmd.rep_start = 1'b1;
              state_nxt     = ST_REPL;
            end
          end else begin
            state_nxt = sts.fin ? ST_FLUSH : ST_FINISH;
          end
        end
      end
      ST_REPL: begin
        if (sts.slot_free) begin
          cmd.rep_emit = 1'b1;
          if (sts.rep_last) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.fill_zero) begin
          state_nxt = ST_FINISH;
        end else if (sts.slot_free) begin
          cmd.release_oldest = 1'b1;
          if (sts.fill_one) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/stream_substring_replace.sv =====
// Streaming find-and-replace: text bytes enter one per transfer, and every
// leftmost, non-overlapping occurrence of the configured pattern (up to
// PATTERN_MAX bytes) leaves as the configured replacement (up to REPLACE_MAX
// bytes, zero deletes the match); all other bytes pass in order. A byte with
// final_byte set flushes the held partial match and tags the last result
// with end_of_text, or gives a bare end marker if it produced nothing. A zero
// pattern length makes every transfer return one result with failed set.
// One item is handled at a time: the block accepts it, releases or emits
// bytes one by one, decides on the remaining window unless releases have
// emptied it, and closes the item. Output stalls hold up each release,
// emission, decision and close.
// Configuration is taken at any time (cfg_ready stays high) but must only
// change while the block is idle.
module stream_substring_replace
  import ssr_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  ssr_cmd_t cmd;
  ssr_sts_t sts;

  assign cfg_ready = 1'b1;

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssr_dp #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/ssr_checker.sv =====
module ssr_checker
  import ssr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A failure result carries no byte and no end mark.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.failed |-> !out_data.byte_present && !out_data.end_of_text)
    else $error("failure result carries a byte or an end mark");

  // A result without a byte is either a failure or a bare end marker.
  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_present |-> out_data.failed || out_data.end_of_text)
    else $error("empty result is neither failure nor end marker");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/stream_substring_replace_tb.sv =====
`timescale 1ns / 1ps

module stream_substring_replace_tb;
  import ssr_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 245;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam int NO_IDLE_FROM  = 100;
  localparam int NO_IDLE_TO    = 160;

  typedef struct packed {
    logic        is_cfg;
    logic [63:0] pb;
    logic [3:0]  pl;
    logic [63:0] rb;
    logic [3:0]  rl;
    in_item_t    item;
    logic        typed;
    out_item_t   want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  // Shadow copy of the registers and the partial-match window.
  logic [63:0] pat_word;
  logic [63:0] rep_word;
  logic [3:0]  pat_len;
  logic [3:0]  rep_len;
  logic [7:0]  held [8];
  logic [3:0]  held_n;

  out_item_t   step_out[$];
  out_item_t   rewritten_q[$];
  out_item_t   head;

  bit          idle_on;
  bit          hold_req;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned settings;
  int unsigned errors;
  int unsigned cycle_count;

  stream_substring_replace dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit(logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    r.byte_present = 1'b1;
    step_out.push_back(r);
  endfunction

  function automatic void release_held();
    emit(held[0]);
    for (int i = 1; i < 8; i++) held[i-1] = held[i];
    held_n--;
  endfunction

  // Computes the results that one text byte produces and advances the window.
  function automatic void rewrite_byte(in_item_t it);
    int          plen;
    int          rlen;
    bit          prefix;
    bit          settled;
    out_item_t   r;
    step_out.delete();
    plen = (pat_len > 4'(PATTERN_MAX_DEF)) ? PATTERN_MAX_DEF : int'(pat_len);
    rlen = (rep_len > 4'(REPLACE_MAX_DEF)) ? REPLACE_MAX_DEF : int'(rep_len);
    if (plen == 0) begin
      held_n = '0;
      r = '0;
      r.failed = 1'b1;
      step_out.push_back(r);
      return;
    end
    if (held_n >= 4'd8) release_held();
    held[held_n[2:0]] = it.text_byte;
    held_n++;
    settled = 1'b0;
    // Drop the oldest byte until what is left is again a prefix of the pattern.
    while (held_n != '0 && !settled) begin
      prefix = (int'(held_n) <= plen);
      for (int i = 0; i < int'(held_n); i++)
        if (held[i] != pat_word[8*i +: 8]) prefix = 1'b0;
      if (prefix) begin
        if (int'(held_n) == plen) begin
          for (int i = 0; i < rlen; i++) emit(rep_word[8*i +: 8]);
          held_n = '0;
        end
        settled = 1'b1;
      end else begin
        release_held();
      end
    end
    if (it.final_byte) begin
      while (held_n != '0) release_held();
      if (step_out.size() == 0) begin
        r = '0;
      end else begin
        r = step_out.pop_back();
      end
      r.end_of_text = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PATTERN_BYTES:      pat_word = data;
      CFG_PATTERN_LENGTH:     pat_len  = data[3:0];
      CFG_REPLACEMENT_BYTES:  rep_word = data;
      CFG_REPLACEMENT_LENGTH: rep_len  = data[3:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [63:0] pb, logic [3:0] pl, logic [63:0] rb,
                              logic [3:0] rl);
    put_reg(CFG_PATTERN_BYTES, pb);
    put_reg(CFG_PATTERN_LENGTH, {60'd0, pl});
    put_reg(CFG_REPLACEMENT_BYTES, rb);
    put_reg(CFG_REPLACEMENT_LENGTH, {60'd0, rl});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // A byte inside a partial match produces nothing, so after the last expected
  // result wait SETTLE_CYCLES more for the block to finish its current item.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_byte(in_item_t it, logic typed, out_item_t want);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rewrite_byte(it);
    if (typed) begin
      rewritten_q.push_back(want);
    end else begin
      foreach (step_out[k]) rewritten_q.push_back(step_out[k]);
    end
    bytes_sent++;
  endtask

  function automatic stim_row_t cfg_row(logic [63:0] pb, logic [3:0] pl, logic [63:0] rb,
                                        logic [3:0] rl);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.pb = pb;
    r.pl = pl;
    r.rb = rb;
    r.rl = rl;
    return r;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] b, logic fin);
    stim_row_t r;
    r = '0;
    r.item.text_byte  = b;
    r.item.final_byte = fin;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [7:0] b, logic fin, logic [7:0] o,
                                          logic present, logic eot, logic fail);
    stim_row_t r;
    r = byte_row(b, fin);
    r.typed = 1'b1;
    r.want.out_byte     = o;
    r.want.byte_present = present;
    r.want.end_of_text  = eot;
    r.want.failed       = fail;
    return r;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 36);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (rewritten_q.size() == 0) begin
        errors++;
        $error("result transfer with nothing expected: out_byte %0h present %0b end %0b",
               out_data.out_byte, out_data.byte_present, out_data.end_of_text);
      end else begin
        head = rewritten_q.pop_front();
        if (head.out_byte !== out_data.out_byte) begin
          errors++;
          $error("out_byte: expected %0h, got %0h", head.out_byte, out_data.out_byte);
        end
        if (head.byte_present !== out_data.byte_present) begin
          errors++;
          $error("byte_present: expected %0b, got %0b", head.byte_present,
                 out_data.byte_present);
        end
        if (head.end_of_text !== out_data.end_of_text) begin
          errors++;
          $error("end_of_text: expected %0b, got %0b", head.end_of_text,
                 out_data.end_of_text);
        end
        if (head.failed !== out_data.failed) begin
          errors++;
          $error("failed: expected %0b, got %0b", head.failed, out_data.failed);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows[$];
    logic [7:0]  txt[$];
    logic [63:0] pb;
    logic [63:0] rb;
    logic [7:0]  a0;
    logic [7:0]  a1;
    int unsigned plen_r;
    int unsigned rlen_r;
    int unsigned len;
    int unsigned lanes;
    int unsigned start;
    int unsigned ph;
    bit          alpha_mode;
    bit          close_text;
    in_item_t    it;
    out_item_t   none;

    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_PATTERN_BYTES;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    pat_word    = '0;
    rep_word    = '0;
    pat_len     = '0;
    rep_len     = '0;
    held_n      = '0;
    for (int i = 0; i < 8; i++) held[i] = '0;
    none        = '0;
    bytes_sent  = 0;
    results_seen = 0;
    settings    = 0;
    errors      = 0;
    cycle_count = 0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Registers come out of reset as zero, so the empty pattern fails every byte.
    rows.push_back(known_row(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
    rows.push_back(known_row(8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1));
    // Pattern "A" with an empty replacement: a lone match leaves a bare end marker.
    rows.push_back(cfg_row(64'h41, 4'd1, 64'h0, 4'd0));
    rows.push_back(known_row(8'h41, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0));
    rows.push_back(known_row(8'h42, 1'b1, 8'h42, 1'b1, 1'b1, 1'b0));
    rows.push_back(known_row(8'h80, 1'b0, 8'h80, 1'b1, 1'b0, 1'b0));
    rows.push_back(byte_row(8'h7F, 1'b0));
    // "aab" -> "XY": the text "aaab" needs a retry after the first mismatch.
    rows.push_back(cfg_row(64'h626161, 4'd3, 64'h5958, 4'd2));
    rows.push_back(byte_row(8'h61, 1'b0));
    rows.push_back(byte_row(8'h61, 1'b0));
    rows.push_back(byte_row(8'h61, 1'b0));
    rows.push_back(byte_row(8'h62, 1'b0));
    rows.push_back(byte_row(8'h61, 1'b0));
    rows.push_back(byte_row(8'h61, 1'b1));
    // Oversized lengths clamp to the full eight bytes on both sides.
    rows.push_back(cfg_row('1, 4'd15, 64'h0123456789ABCDEF, 4'd15));
    for (int i = 0; i < 10; i++) rows.push_back(byte_row(8'hFF, 1'b0));
    // Two bytes are held when the pattern shrinks to one byte.
    rows.push_back(cfg_row(64'hFF, 4'd1, 64'h525252, 4'd3));
    rows.push_back(byte_row(8'h00, 1'b1));

    foreach (rows[n]) begin
      if (rows[n].is_cfg) begin
        wait_idle();
        load_setting(rows[n].pb, rows[n].pl, rows[n].rb, rows[n].rl);
      end else begin
        send_byte(rows[n].item, rows[n].typed, rows[n].want);
      end
    end

    start = bytes_sent;
    ph = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      wait_idle();
      a0 = 8'($urandom);
      a1 = 8'($urandom);
      alpha_mode = ($urandom_range(99) < 70);
      if (alpha_mode) begin
        for (int i = 0; i < 8; i++) pb[8*i +: 8] = $urandom_range(1) ? a1 : a0;
      end else begin
        pb = {$urandom, $urandom};
      end
      rb = {$urandom, $urandom};
      case ($urandom_range(99)) inside
        [0:5]:   plen_r = 0;
        [6:13]:  plen_r = $urandom_range(15, 9);
        default: plen_r = $urandom_range(8, 1);
      endcase
      case ($urandom_range(99)) inside
        [0:14]:  rlen_r = 0;
        [15:29]: rlen_r = $urandom_range(15, 9);
        default: rlen_r = $urandom_range(8, 1);
      endcase
      len = $urandom_range(24, 1);
      close_text = ($urandom_range(99) < 80);
      // The hold-off phase mostly passes bytes through so the block backs up.
      if (ph == 2) begin
        plen_r = 1;
        len = 30;
        close_text = 1'b1;
      end
      load_setting(pb, 4'(plen_r), rb, 4'(rlen_r));

      lanes = (plen_r > 8) ? 8 : plen_r;
      txt.delete();
      while (txt.size() < len) begin
        case ($urandom_range(3))
          0: begin
            if (lanes == 0) txt.push_back(a0);
            for (int i = 0; i < lanes; i++) txt.push_back(pb[8*i +: 8]);
          end
          3:       txt.push_back(8'($urandom));
          default: txt.push_back($urandom_range(1) ? a1 : a0);
        endcase
      end

      if (ph == 2) hold_req = 1'b1;
      foreach (txt[i]) begin
        idle_on = !(bytes_sent - start >= NO_IDLE_FROM && bytes_sent - start < NO_IDLE_TO);
        it.text_byte  = txt[i];
        it.final_byte = close_text && (i == txt.size() - 1);
        send_byte(it, 1'b0, none);
      end
      ph++;
    end
    idle_on = 1'b1;
    wait_idle();

    $display("Sent %0d text bytes under %0d register settings; %0d result transfers checked.",
             bytes_sent, settings, results_seen);
    $display("Included empty and oversized lengths, pattern swaps mid-text and a long hold.");
    if (errors == 0 && rewritten_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
